[design/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// dsr_pkg: shared constants for the dimension spread ranker
// Field widths of the stream payloads and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

    // default configuration of the top level
    localparam int DEF_MAX_DIMS   = 16;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths
    localparam int COORD_W  = 16;
    localparam int RANK_W   = 4;
    localparam int DIMIDX_W = 4;
    localparam int SPREAD_W = 16;
    localparam int CFG_W    = 5;

    // packed stream widths
    localparam int S_DATA_W = COORD_W;
    localparam int M_DATA_W = RANK_W + DIMIDX_W + SPREAD_W;

    // register reset value
    localparam logic [CFG_W-1:0] DIMS_RESET = CFG_W'(1);

endpackage

`default_nettype wire

[design/dsr_ram.sv]
// ----------------------------------------------------------------------------
// dsr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/dimension_spread_ranker.sv]
// A coordinate is folded into its min/max entry in the cycle after it is accepted, and the input
// takes no new coordinate until that fold is written back (read-modify-write of the tracker RAM).
// After the flagged coordinate, each of the n ranks scans all n tracker entries through the
// one RAM read port and the shared subtract/compare unit, then holds its result on the
// output until the transaction completes.
// Reset: dims_in_use returns to 1, all trackers read as empty, no clearing pass is needed.
// ----------------------------------------------------------------------------
// dimension_spread_ranker: orders the dimensions of a point set by spread
// Tracks min/max per dimension over a coordinate stream and, at the end of
// a set, emits the dimensions widest spread first, ties to the lower index.
// ----------------------------------------------------------------------------
`default_nettype none

module dimension_spread_ranker
    import dsr_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [15:0] coord
    input  wire logic                s_tlast,   // last_coord
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [3:0] rank, [7:4] dim_index, [23:8] spread
    output logic                     m_tlast,   // last_result
    // configuration write (dims_in_use)
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int W     = COORD_BITS;
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                state_reg,    state_next;
    logic [CFG_W-1:0]      dims_reg,     dims_next;
    logic [DIM_W-1:0]      cnt_reg,      cnt_next;
    logic [DIM_W-1:0]      dsel_reg,     dsel_next;
    logic [W-1:0]          coord_reg,    coord_next;
    logic                  last_reg,     last_next;
    logic [MAX_DIMS-1:0]   vld_reg,      vld_next;
    logic [MAX_DIMS-1:0]   used_reg,     used_next;
    logic [CNT_W-1:0]      kiss_reg,     kiss_next;
    logic                  pv_reg,       pv_next;
    logic [DIM_W-1:0]      pidx_reg,     pidx_next;
    logic                  found_reg,    found_next;
    logic [DIM_W-1:0]      best_reg,     best_next;
    logic [W-1:0]          bspr_reg,     bspr_next;
    logic [CNT_W-1:0]      rank_reg,     rank_next;
    logic                  mvalid_reg,   mvalid_next;
    logic [RANK_W-1:0]     orank_reg,    orank_next;
    logic [DIMIDX_W-1:0]   odim_reg,     odim_next;
    logic [SPREAD_W-1:0]   ospr_reg,     ospr_next;
    logic                  olast_reg,    olast_next;

    logic [CNT_W-1:0]      n_act;
    logic [DIM_W-1:0]      d_sel;
    logic [CNT_W-1:0]      d_inc;
    logic                  s_acc;
    logic                  issue;
    logic                  ram_we;
    logic [DIM_W-1:0]      ram_raddr;
    logic [2*W-1:0]        ram_wdata;
    logic [2*W-1:0]        ram_rdata;
    logic signed [W-1:0]   rd_min;
    logic signed [W-1:0]   rd_max;
    logic signed [W-1:0]   cur_coord;
    logic signed [W-1:0]   new_min;
    logic signed [W-1:0]   new_max;
    logic signed [W:0]     diff;
    logic [W-1:0]          spr_cur;
    logic                  take;

    // min/max tracker store, {max, min} per dimension
    dsr_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_DIMS),
        .ADDR_W(DIM_W)
    ) u_trk_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(dsel_reg),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // active dimension count, out-of-range register values clamped
    always_comb begin
        if (dims_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(dims_reg) > MAX_DIMS) begin
            n_act = CNT_W'(MAX_DIMS);
        end else begin
            n_act = CNT_W'(dims_reg);
        end
    end

    // dimension of the incoming coordinate
    assign d_sel = (CNT_W'(cnt_reg) >= n_act) ? '0 : cnt_reg;
    assign d_inc = CNT_W'(d_sel) + CNT_W'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // shared read port: tracker lookup on accept, entry walk while scanning
    assign issue     = (state_reg == ST_SCAN) && (kiss_reg < n_act);
    assign ram_raddr = (state_reg == ST_SCAN) ? (issue ? kiss_reg[DIM_W-1:0] : '0) : d_sel;

    assign rd_min    = $signed(ram_rdata[W-1:0]);
    assign rd_max    = $signed(ram_rdata[2*W-1:W]);
    assign cur_coord = $signed(coord_reg);

    // min/max fold, an empty entry takes the coordinate as is
    always_comb begin
        new_min = (!vld_reg[dsel_reg] || (cur_coord < rd_min)) ? cur_coord : rd_min;
        new_max = (!vld_reg[dsel_reg] || (cur_coord > rd_max)) ? cur_coord : rd_max;
    end

    assign ram_we    = (state_reg == ST_UPDATE);
    assign ram_wdata = {new_max, new_min};

    // spread of the entry under evaluation and best-so-far compare
    assign diff    = {rd_max[W-1], rd_max} - {rd_min[W-1], rd_min};
    assign spr_cur = vld_reg[pidx_reg] ? diff[W-1:0] : '0;
    assign take    = pv_reg && !used_reg[pidx_reg] && (!found_reg || (spr_cur > bspr_reg));

    // sequencer next state
    always_comb begin
        state_next  = state_reg;
        dims_next   = dims_reg;
        cnt_next    = cnt_reg;
        dsel_next   = dsel_reg;
        coord_next  = coord_reg;
        last_next   = last_reg;
        vld_next    = vld_reg;
        used_next   = used_reg;
        kiss_next   = kiss_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bspr_next   = bspr_reg;
        rank_next   = rank_reg;
        mvalid_next = mvalid_reg;
        orank_next  = orank_reg;
        odim_next   = odim_reg;
        ospr_next   = ospr_reg;
        olast_next  = olast_reg;

        if (cfg_valid && cfg_ready) begin
            dims_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                // take a coordinate, the RAM read of its entry is in flight
                if (s_acc) begin
                    dsel_next  = d_sel;
                    coord_next = W'(s_tdata[COORD_W-1:0]);
                    last_next  = s_tlast;
                    cnt_next   = (d_inc >= n_act) ? '0 : d_inc[DIM_W-1:0];
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // write back the folded entry
                vld_next[dsel_reg] = 1'b1;
                if (last_reg) begin
                    rank_next  = '0;
                    kiss_next  = '0;
                    pv_next    = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // walk all entries, keep the widest unused one
                if (issue) begin
                    kiss_next = kiss_reg + CNT_W'(1);
                    pidx_next = kiss_reg[DIM_W-1:0];
                    pv_next   = 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
                if (take) begin
                    found_next = 1'b1;
                    best_next  = pidx_reg;
                    bspr_next  = spr_cur;
                end
                if (!issue && !pv_reg) begin
                    used_next[best_reg] = 1'b1;
                    mvalid_next = 1'b1;
                    orank_next  = RANK_W'(rank_reg);
                    odim_next   = DIMIDX_W'(best_reg);
                    ospr_next   = SPREAD_W'(bspr_reg);
                    olast_next  = (CNT_W'(rank_reg + CNT_W'(1)) == n_act);
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the transaction completes
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (olast_reg) begin
                        vld_next   = '0;
                        used_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rank_next  = rank_reg + CNT_W'(1);
                        kiss_next  = '0;
                        pv_next    = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dims_reg   <= DIMS_RESET;
            cnt_reg    <= '0;
            vld_reg    <= '0;
            used_reg   <= '0;
            kiss_reg   <= '0;
            pv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            rank_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dims_reg   <= dims_next;
            cnt_reg    <= cnt_next;
            vld_reg    <= vld_next;
            used_reg   <= used_next;
            kiss_reg   <= kiss_next;
            pv_reg     <= pv_next;
            found_reg  <= found_next;
            rank_reg   <= rank_next;
            mvalid_reg <= mvalid_next;
        end
        dsel_reg  <= dsel_next;
        coord_reg <= coord_next;
        last_reg  <= last_next;
        pidx_reg  <= pidx_next;
        best_reg  <= best_next;
        bspr_reg  <= bspr_next;
        orank_reg <= orank_next;
        odim_reg  <= odim_next;
        ospr_reg  <= ospr_next;
        olast_reg <= olast_next;
    end

    // result port
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {ospr_reg, odim_reg, orank_reg};
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

[sim/tb_dimension_spread_ranker.sv]
// ----------------------------------------------------------------------------
// tb_dimension_spread_ranker: self-checking bench for the spread ranker
// Streams coordinate sets through the block, predicts the per-dimension
// ordering by spread and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tb_dimension_spread_ranker;

    timeunit 1ns;
    timeprecision 1ps;

    import dsr_pkg::*;

    localparam int MAX_DIMS      = DEF_MAX_DIMS;
    localparam int RANDOM_COORDS = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [COORD_W-1:0] COORD_MOST_NEG = 16'h8000;
    localparam logic [COORD_W-1:0] COORD_MOST_POS = 16'h7FFF;

    typedef enum int {STYLE_FULL, STYLE_NARROW, STYLE_EXTREME} coord_style_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [DIMIDX_W-1:0] dim_idx;
        logic [SPREAD_W-1:0] spread;
        logic                last;
    } rank_entry_t;

    // dut ports
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // [15:0] coord
    logic                s_tlast   = 1'b0; // last_coord
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // [3:0] rank, [7:4] dim_index, [23:8] spread
    logic                m_tlast;          // last_result
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // predictor state
    logic [CFG_W-1:0] dims_reg = DIMS_RESET;
    int               dim_lo [MAX_DIMS];
    int               dim_hi [MAX_DIMS];
    int               dim_cursor;
    rank_entry_t      ranking_q [$];

    int  ranking_errors = 0;
    int  coords_sent    = 0;
    int  cycle_count    = 0;
    int  ready_stall    = 0;
    bit  steady_flow    = 1'b0;

    dimension_spread_ranker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_dims(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIMS)
            return MAX_DIMS;
        return int'(v);
    endfunction

    function automatic void clear_trackers();
        for (int d = 0; d < MAX_DIMS; d++) begin
            dim_lo[d] = 32767;
            dim_hi[d] = -32768;
        end
        dim_cursor = 0;
    endfunction

    // fold one coordinate into the trackers, queue the ordering on the flag
    function automatic void predict_ordering(input logic [COORD_W-1:0] coord, input logic flag);
        int          n, d, r, k, best, v;
        int          spr [MAX_DIMS];
        bit          taken [MAX_DIMS];
        bit          found;
        rank_entry_t ent;
        n = clamp_dims(dims_reg);
        v = $signed(coord);
        d = (dim_cursor >= n) ? 0 : dim_cursor;
        if (v < dim_lo[d])
            dim_lo[d] = v;
        if (v > dim_hi[d])
            dim_hi[d] = v;
        dim_cursor = (d + 1 >= n) ? 0 : d + 1;
        if (flag) begin
            for (d = 0; d < n; d++) begin
                spr[d]   = (dim_hi[d] < dim_lo[d]) ? 0 : dim_hi[d] - dim_lo[d];
                taken[d] = 1'b0;
            end
            // selection by descending spread, ties keep the lower index
            for (r = 0; r < n; r++) begin
                best  = 0;
                found = 1'b0;
                for (k = 0; k < n; k++) begin
                    if (!taken[k] && (!found || spr[k] > spr[best])) begin
                        best  = k;
                        found = 1'b1;
                    end
                end
                taken[best] = 1'b1;
                ent.rank    = RANK_W'(r);
                ent.dim_idx = DIMIDX_W'(best);
                ent.spread  = SPREAD_W'(spr[best]);
                ent.last    = (r == n - 1);
                ranking_q.push_back(ent);
            end
            clear_trackers();
        end
    endfunction

    // one coordinate transaction on the input stream
    task automatic send_coord(input logic [COORD_W-1:0] coord, input logic flag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= coord;
        s_tlast  <= flag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_ordering(coord, flag);
        coords_sent++;
    endtask

    // hold the input until every queued result has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (ranking_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        dims_reg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input coord_style_t style);
        case (style)
            STYLE_NARROW: return COORD_W'($urandom_range(0, 4) - 2);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MOST_NEG;
                    1: return COORD_MOST_POS;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return COORD_W'($urandom);
                endcase
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dims();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return CFG_W'($urandom_range(1, 6));
        if (r < 85)
            return CFG_W'($urandom_range(7, 16));
        if (r < 92)
            return '0;
        return CFG_W'($urandom_range(17, 31));
    endfunction

    // result side backpressure
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            m_tready    <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_stall <= pick_gap();
        end
    end

    // result checker
    always @(posedge aclk) begin
        rank_entry_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rank    = m_tdata[3:0];
            got.dim_idx = m_tdata[7:4];
            got.spread  = m_tdata[23:8];
            got.last    = m_tlast;
            if (ranking_q.size() == 0) begin
                ranking_errors++;
                if (ranking_errors <= REPORT_LIMIT)
                    $display("mismatch: unexpected result rank %0d dim %0d spread %0d last %0b",
                             got.rank, got.dim_idx, got.spread, got.last);
            end else begin
                want = ranking_q.pop_front();
                if (got !== want) begin
                    ranking_errors++;
                    if (ranking_errors <= REPORT_LIMIT)
                        $display("mismatch: expected rank %0d dim %0d spread %0d last %0b, %s",
                                 want.rank, want.dim_idx, want.spread, want.last,
                                 $sformatf("got rank %0d dim %0d spread %0d last %0b",
                                           got.rank, got.dim_idx, got.spread, got.last));
                end
            end
        end
    end

    // reset value of the register, extreme coordinates, full-scale spread
    task automatic test_reset_extremes();
        send_coord(COORD_MOST_NEG, 1'b0);
        send_coord(COORD_MOST_POS, 1'b1);
    endtask

    // zero acts as one, above the maximum acts as the maximum, all-tie ordering
    task automatic test_register_range();
        write_dims('0);
        send_coord(16'd5, 1'b1);
        write_dims(CFG_W'(31));
        for (int k = 0; k < MAX_DIMS; k++)
            send_coord(COORD_W'(k * 1000), k == MAX_DIMS - 1);
    endtask

    // flag in mid-point, unsampled dimensions, counter beyond a lowered register
    task automatic test_partial_sets();
        write_dims(CFG_W'(4));
        send_coord(16'd10, 1'b0);
        send_coord(-16'sd20, 1'b1);
        send_coord(16'd1, 1'b0);
        send_coord(16'd2, 1'b0);
        send_coord(16'd3, 1'b0);
        write_dims(CFG_W'(2));
        send_coord(16'd100, 1'b1);
    endtask

    // random sets with random register settings and mid-set changes
    task automatic test_random_sets();
        int           start, n, pts, len, cut;
        coord_style_t style;
        start = coords_sent;
        while (coords_sent - start < RANDOM_COORDS) begin
            if ($urandom_range(0, 9) < 3)
                write_dims(pick_dims());
            if ($urandom_range(0, 4) == 0)
                steady_flow = !steady_flow;
            style = coord_style_t'($urandom_range(0, 2));
            n     = clamp_dims(dims_reg);
            pts   = (n <= 4) ? $urandom_range(1, 6) : $urandom_range(1, 3);
            len   = n * pts;
            if ($urandom_range(0, 9) == 0)
                len = len - $urandom_range(0, n - 1);
            cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
            for (int k = 0; k < len; k++) begin
                if (cut != 0 && k == cut)
                    write_dims(pick_dims());
                send_coord(pick_coord(style), k == len - 1);
            end
        end
        steady_flow = 1'b0;
    endtask

    // test sequence
    initial begin
        clear_trackers();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_extremes();
        test_register_range();
        test_partial_sets();
        test_random_sets();
        wait_idle();
        if (ranking_errors == 0 && ranking_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
